// ===== rtl/pkc_pkg.sv =====
// Package for the power key press classifier.
// Holds the beat structs, the register file struct and the shared codes.
// Depends on nothing; every other file in rtl/ imports it.
`default_nettype none

package pkc_pkg;

   // Input beat kinds
   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_KEY  = 2'd1;
   localparam logic [1:0] KIND_MODE = 2'd2;

   // Key event values
   localparam logic [1:0] VAL_RELEASE = 2'd0;
   localparam logic [1:0] VAL_PRESS   = 2'd1;

   // Reported press classes
   localparam logic [1:0] CLASS_NONE   = 2'd0;
   localparam logic [1:0] CLASS_SHORT  = 2'd1;
   localparam logic [1:0] CLASS_LONG   = 2'd2;
   localparam logic [1:0] CLASS_DOUBLE = 2'd3;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_CODE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_DLY   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MEDIUM_DLY = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOUBLE_WIN = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORT_DLY  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORT_ACT  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_ACT   = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOUBLE_ACT = 3'd7;

   // Register reset values
   localparam logic [9:0]  RST_KEY_CODE   = 10'd116;
   localparam logic [15:0] RST_LONG_DLY   = 16'd1000;
   localparam logic [15:0] RST_MEDIUM_DLY = 16'd500;
   localparam logic [15:0] RST_DOUBLE_WIN = 16'd300;
   localparam logic [15:0] RST_SHORT_DLY  = 16'd300;
   localparam logic [2:0]  RST_SHORT_ACT  = 3'd1;
   localparam logic [2:0]  RST_LONG_ACT   = 3'd2;
   localparam logic [2:0]  RST_DOUBLE_ACT = 3'd4;

   typedef struct packed {
      logic [1:0] kind;
      logic [9:0] key_code;
      logic [1:0] key_value;
      logic       eat_events;
      logic       startup_context;
   } pkc_req_type;

   typedef struct packed {
      logic [1:0] press_class;
      logic [2:0] action_code;
      logic       context_startup;
      logic       feedback_on;
      logic       feedback_off;
   } pkc_rsp_type;

   typedef struct packed {
      logic [9:0]  key_code_match;
      logic [15:0] long_delay_ms;
      logic [15:0] medium_delay_ms;
      logic [15:0] double_window_ms;
      logic [15:0] short_delay_ms;
      logic [2:0]  short_action_code;
      logic [2:0]  long_action_code;
      logic [2:0]  double_action_code;
   } pkc_cfg_type;

endpackage

`default_nettype wire

// ===== rtl/pkc_csr.sv =====
// Configuration register file of the power key press classifier.
// Uses pkc_pkg for register indexes, reset values and the cfg struct.
`default_nettype none

module pkc_csr
   import pkc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data,
   output pkc_cfg_type                    cfg
);

   pkc_cfg_type cfg_ff;
   pkc_cfg_type cfg_in;

   // Decode the write into the addressed field, truncating to its width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY_CODE:   cfg_in.key_code_match     = csr_write_data[9:0];
            CSR_LONG_DLY:   cfg_in.long_delay_ms      = csr_write_data;
            CSR_MEDIUM_DLY: cfg_in.medium_delay_ms    = csr_write_data;
            CSR_DOUBLE_WIN: cfg_in.double_window_ms   = csr_write_data;
            CSR_SHORT_DLY:  cfg_in.short_delay_ms     = csr_write_data;
            CSR_SHORT_ACT:  cfg_in.short_action_code  = csr_write_data[2:0];
            CSR_LONG_ACT:   cfg_in.long_action_code   = csr_write_data[2:0];
            CSR_DOUBLE_ACT: cfg_in.double_action_code = csr_write_data[2:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_code_match     <= RST_KEY_CODE;
         cfg_ff.long_delay_ms      <= RST_LONG_DLY;
         cfg_ff.medium_delay_ms    <= RST_MEDIUM_DLY;
         cfg_ff.double_window_ms   <= RST_DOUBLE_WIN;
         cfg_ff.short_delay_ms     <= RST_SHORT_DLY;
         cfg_ff.short_action_code  <= RST_SHORT_ACT;
         cfg_ff.long_action_code   <= RST_LONG_ACT;
         cfg_ff.double_action_code <= RST_DOUBLE_ACT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/pkc_core.sv =====
// Classifier state and next-result logic of the power key press classifier.
// Uses pkc_pkg for the beat structs, codes and the cfg struct.
`default_nettype none

module pkc_core
   import pkc_pkg::*;
#(
   parameter int unsigned TIME_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire pkc_req_type item,
   input  wire pkc_cfg_type cfg,
   output pkc_rsp_type      result
);

   // Timekeeping and classifier state
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIME_BITS-1:0] last_press_ff, last_press_in;
   logic [TIME_BITS-1:0] mode_change_ff, mode_change_in;
   logic [TIME_BITS-1:0] short_deadline_ff, short_deadline_in;
   logic [15:0]          hold_delay_ff, hold_delay_in;
   logic press_seen_ff, press_seen_in;
   logic long_pending_ff, long_pending_in;
   logic short_pending_ff, short_pending_in;
   logic short_context_ff, short_context_in;
   logic release_armed_ff, release_armed_in;
   logic eaten_ff, eaten_in;

   logic [TIME_BITS-1:0] tick_now;
   logic [TIME_BITS-1:0] tick_gap;
   logic [TIME_BITS-1:0] press_gap;
   logic                 blocked;
   logic                 key_match;

   assign tick_now  = now_ff + TIME_BITS'(1);
   assign tick_gap  = tick_now - last_press_ff;
   assign press_gap = now_ff - last_press_ff;
   assign blocked   = now_ff < mode_change_ff;
   assign key_match = item.key_code == cfg.key_code_match;

   // Work out the next state and the result of this beat
   always_comb begin
      now_in            = now_ff;
      last_press_in     = last_press_ff;
      mode_change_in    = mode_change_ff;
      short_deadline_in = short_deadline_ff;
      hold_delay_in     = hold_delay_ff;
      press_seen_in     = press_seen_ff;
      long_pending_in   = long_pending_ff;
      short_pending_in  = short_pending_ff;
      short_context_in  = short_context_ff;
      release_armed_in  = release_armed_ff;
      eaten_in          = eaten_ff;
      result            = '0;

      unique case (item.kind)
         KIND_TICK: begin
            now_in = tick_now;
            if (long_pending_ff && (tick_gap >= TIME_BITS'(hold_delay_ff))) begin
               long_pending_in = 1'b0;
               // drop the long report for a press made before the mode change
               if (!(last_press_ff < mode_change_ff)) begin
                  result.press_class     = CLASS_LONG;
                  result.action_code     = cfg.long_action_code;
                  result.context_startup = short_context_ff;
                  release_armed_in       = 1'b0;
               end
            end else if (short_pending_ff && (tick_now == short_deadline_ff)) begin
               short_pending_in       = 1'b0;
               result.press_class     = CLASS_SHORT;
               result.action_code     = cfg.short_action_code;
               result.context_startup = short_context_ff;
               result.feedback_off    = short_context_ff;
            end
         end
         KIND_MODE: begin
            mode_change_in = now_ff;
         end
         KIND_KEY: begin
            priority if (key_match && item.key_value == VAL_PRESS) begin
               eaten_in         = item.eat_events;
               short_pending_in = 1'b0;
               if (!item.eat_events) begin
                  result.feedback_on = item.startup_context;
                  hold_delay_in = item.startup_context ? cfg.medium_delay_ms
                                                       : cfg.long_delay_ms;
                  if (press_seen_ff &&
                      (press_gap < TIME_BITS'(cfg.double_window_ms))) begin
                     long_pending_in = 1'b0;
                     if (!blocked) begin
                        result.press_class     = CLASS_DOUBLE;
                        result.action_code     = cfg.double_action_code;
                        result.context_startup = item.startup_context;
                     end
                     release_armed_in = 1'b0;
                  end else if (!blocked) begin
                     long_pending_in  = 1'b1;
                     release_armed_in = 1'b1;
                     short_context_in = item.startup_context;
                  end else begin
                     release_armed_in = 1'b0;
                  end
                  last_press_in = now_ff;
                  press_seen_in = 1'b1;
               end
            end else if (key_match && item.key_value == VAL_RELEASE) begin
               long_pending_in = 1'b0;
               if (!eaten_ff && release_armed_ff) begin
                  if (!blocked) begin
                     if (press_gap > TIME_BITS'(hold_delay_ff)) begin
                        result.press_class     = CLASS_LONG;
                        result.action_code     = cfg.long_action_code;
                        result.context_startup = item.startup_context;
                     end else if (cfg.short_delay_ms != '0) begin
                        // defer the short report, capture the release context
                        short_pending_in  = 1'b1;
                        short_deadline_in = now_ff + TIME_BITS'(cfg.short_delay_ms);
                        short_context_in  = item.startup_context;
                     end else begin
                        result.press_class     = CLASS_SHORT;
                        result.action_code     = cfg.short_action_code;
                        result.context_startup = item.startup_context;
                     end
                  end
                  result.feedback_off = item.startup_context;
               end
               release_armed_in = 1'b0;
            end else begin
               // other key or autorepeat: ignore
               result = '0;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // Advance the state on each processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff            <= '0;
         last_press_ff     <= '0;
         mode_change_ff    <= '0;
         short_deadline_ff <= '0;
         hold_delay_ff     <= RST_LONG_DLY;
         press_seen_ff     <= 1'b0;
         long_pending_ff   <= 1'b0;
         short_pending_ff  <= 1'b0;
         short_context_ff  <= 1'b0;
         release_armed_ff  <= 1'b0;
         eaten_ff          <= 1'b0;
      end else if (step) begin
         now_ff            <= now_in;
         last_press_ff     <= last_press_in;
         mode_change_ff    <= mode_change_in;
         short_deadline_ff <= short_deadline_in;
         hold_delay_ff     <= hold_delay_in;
         press_seen_ff     <= press_seen_in;
         long_pending_ff   <= long_pending_in;
         short_pending_ff  <= short_pending_in;
         short_context_ff  <= short_context_in;
         release_armed_ff  <= release_armed_in;
         eaten_ff          <= eaten_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/power_key_press_classifier.sv =====
// Power key press classifier: classifies presses of one key as short, long
// or double from millisecond ticks, key events and mode changes.
//
// Channels: req_valid/req_stall/req_data carry input beats (tick, key event,
// mode change); rsp_valid/rsp_stall/rsp_data carry one result beat per input
// beat, press_class CLASS_NONE when nothing is reported. A beat moves when
// valid is high and stall is low. The csr_ port writes one register per
// cycle with csr_write_enable; write only while no beat is in flight.
//
// Path: an input beat is captured in the input register, then its result in the
// result register. Throughput: one beat per cycle while rsp_stall is low; the
// classifier state updates as a beat moves between the two registers.
//
// Reset (synchronous): registers return to their defaults, time and press
// state clear, both pipeline registers empty. When the receiver stalls, the
// result register holds; the input register takes one more beat if it is empty,
// and req_stall is high while it holds a beat, until the result is taken.
`default_nettype none

module power_key_press_classifier
   import pkc_pkg::*;
#(
   parameter int unsigned TIME_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire pkc_req_type               req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output pkc_rsp_type                    rsp_data,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   pkc_cfg_type cfg;
   pkc_req_type req_ff;
   pkc_rsp_type rsp_ff;
   pkc_rsp_type rsp_in;
   logic        req_valid_ff;
   logic        rsp_valid_ff;
   logic        out_free;
   logic        advance;

   pkc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   pkc_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (req_ff),
      .cfg    (cfg),
      .result (rsp_in)
   );

   // Pipeline control: result register frees when empty or taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;

   // Capture input beats, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
   end

   // Load the result register as the core processes a beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A stall toward the sender only comes from a full input register
   a_stall_needs_item: assert property (@(posedge clock)
      req_stall |-> req_valid_ff)
      else $error("req_stall raised with empty input register");

   // A processed beat always lands in the result register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed beat lost");

   // No class means no action and no context
   a_none_is_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.press_class == CLASS_NONE)
      |-> (rsp_ff.action_code == '0 && rsp_ff.context_startup == 1'b0))
      else $error("action or context reported without a class");

   // Reset empties the result register
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

endmodule

`default_nettype wire
